// File: rtl/assert_macros.svh
// Assertion macros shared by the running median RTL.
// Depends on nothing; expects signals clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, disabled while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication check: antecedent at one edge, consequent at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rmf_pkg.sv
// Package for the running median filter: sizes, types, register codes.
// Used by rmf_cell, rmf_out and running_median_filter; depends on nothing.
`default_nettype none

package rmf_pkg;

  localparam int MAX_WINDOW    = 32;
  localparam int SAMPLE_BITS   = 24;
  localparam int AGE_BITS      = $clog2(MAX_WINDOW);
  localparam int WS_BITS       = 6;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = (SAMPLE_BITS > WS_BITS) ? SAMPLE_BITS : WS_BITS;
  localparam int TDATA_BITS    = ((SAMPLE_BITS + 7) / 8) * 8;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [AGE_BITS-1:0]           age_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WINDOW_SIZE = 2'd0,
    REG_INIT_VALUE  = 2'd1
  } cfg_reg_t;

  // Broadcast to every cell of the window.
  typedef struct packed {
    logic    reinit;
    logic    step;
    logic    up_mode;
    age_t    last;
    sample_t x;
    sample_t init;
  } cell_ctrl_t;

  // Oldest age for a window size, size clamped to 1..MAX_WINDOW.
  function automatic age_t last_age(input logic [WS_BITS-1:0] ws);
    age_t r;
    if (ws == '0) begin
      r = '0;
    end else if (int'(ws) > MAX_WINDOW) begin
      r = age_t'(MAX_WINDOW - 1);
    end else begin
      r = age_t'(ws - 1'b1);
    end
    return r;
  endfunction

  // Median slot: window size >> 1.
  function automatic age_t mid_slot(input age_t last);
    logic [AGE_BITS:0] n;
    n = {1'b0, last} + 1'b1;
    return n[AGE_BITS:1];
  endfunction

endpackage

`default_nettype wire

// File: rtl/running_median_filter.sv
// Running median over the last N samples, a chain of sorted window cells.
// After an input transfer pending is registered; m_tvalid and the median follow once the output is free.
// Throughput: one sample per cycle while m_tready is high; a held result stalls s_tready while one is pending.
// Configuration writes are always accepted (cfg_ready is tied high) and refill the window at once.
// Reset (rst, synchronous): N = 3, init value 0, window filled with 0.
// Depends on rmf_pkg, rmf_cell, rmf_out and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module running_median_filter (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [rmf_pkg::TDATA_BITS-1:0]      s_tdata,   // [23:0] sample_in
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [rmf_pkg::TDATA_BITS-1:0]           m_tdata,   // [23:0] median_out
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rmf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [rmf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int N = rmf_pkg::MAX_WINDOW;

  rmf_pkg::age_t       last;
  rmf_pkg::age_t       mid;
  rmf_pkg::sample_t    init_value;
  rmf_pkg::cell_ctrl_t ctrl;
  rmf_pkg::sample_t    val [N];
  rmf_pkg::age_t       age [N];
  rmf_pkg::sample_t    median;
  logic [N-1:0]        le_vec;
  logic [N-1:0]        del_vec;
  logic [N-1:0]        upto_vec;
  logic                s_ready;
  logic                accept;
  logic                pending;
  logic                wr_ws;
  logic                wr_init;
  logic                sorted_ok;

  assign cfg_ready = 1'b1;
  assign wr_ws     = cfg_valid && (cfg_index == rmf_pkg::REG_WINDOW_SIZE);
  assign wr_init   = cfg_valid && (cfg_index == rmf_pkg::REG_INIT_VALUE);

  always_ff @(posedge clk) begin
    if (rst) begin
      last       <= rmf_pkg::last_age(rmf_pkg::WS_BITS'(3));
      mid        <= rmf_pkg::mid_slot(rmf_pkg::last_age(rmf_pkg::WS_BITS'(3)));
      init_value <= '0;
    end else begin
      if (wr_ws) begin
        last <= rmf_pkg::last_age(cfg_data[rmf_pkg::WS_BITS-1:0]);
        mid  <= rmf_pkg::mid_slot(rmf_pkg::last_age(cfg_data[rmf_pkg::WS_BITS-1:0]));
      end
      if (wr_init) begin
        init_value <= cfg_data[rmf_pkg::SAMPLE_BITS-1:0];
      end
    end
  end

  assign s_tready = s_ready;
  assign accept   = s_tvalid && s_ready;

  always_comb begin
    ctrl.reinit  = wr_ws || wr_init;
    ctrl.step    = accept;
    ctrl.up_mode = |(del_vec & le_vec);
    ctrl.last    = last;
    ctrl.x       = s_tdata[rmf_pkg::SAMPLE_BITS-1:0];
    ctrl.init    = wr_init ? cfg_data[rmf_pkg::SAMPLE_BITS-1:0] : init_value;
  end

  for (genvar j = 0; j < N; j++) begin : g_cell
    rmf_pkg::sample_t pv, nv;
    rmf_pkg::age_t    pa, na;
    logic             pl, nl, bd;

    if (j == 0) begin : g_lo
      assign pv = val[0];
      assign pa = age[0];
      assign pl = 1'b1;
      assign bd = 1'b0;
    end else begin : g_lo
      assign pv = val[j-1];
      assign pa = age[j-1];
      assign pl = le_vec[j-1];
      assign bd = upto_vec[j-1];
    end

    if (j == N - 1) begin : g_hi
      assign nv = val[j];
      assign na = age[j];
      assign nl = 1'b0;
    end else begin : g_hi
      assign nv = val[j+1];
      assign na = age[j+1];
      assign nl = le_vec[j+1];
    end

    rmf_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .idx        (rmf_pkg::age_t'(j)),
      .prev_value (pv),
      .prev_age   (pa),
      .prev_le    (pl),
      .next_value (nv),
      .next_age   (na),
      .next_le    (nl),
      .below_del  (bd),
      .value      (val[j]),
      .age        (age[j]),
      .le         (le_vec[j]),
      .del        (del_vec[j]),
      .upto_del   (upto_vec[j])
    );
  end

  rmf_out u_out (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .values  (val),
    .mid     (mid),
    .m_ready (m_tready),
    .m_valid (m_tvalid),
    .median  (median),
    .s_ready (s_ready),
    .pending (pending)
  );

  assign m_tdata = rmf_pkg::TDATA_BITS'(unsigned'(median));

  always_comb begin
    sorted_ok = 1'b1;
    for (int j = 0; j < N - 1; j++) begin
      if ((rmf_pkg::age_t'(j + 1) <= last) && (val[j] > val[j+1])) begin
        sorted_ok = 1'b0;
      end
    end
  end

  `ASSERT_CLK(a_one_oldest, $onehot(del_vec), "window must hold exactly one oldest entry")
  `ASSERT_CLK(a_sorted, sorted_ok, "window values out of order")
  `ASSERT_NEXT(a_pending, accept, pending, "accepted sample left no pending result")

endmodule

`default_nettype wire

// File: rtl/rmf_cell.sv
// One slot of the sorted window: value and age, updated from its neighbors.
// Depends on rmf_pkg.
`default_nettype none

module rmf_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rmf_pkg::cell_ctrl_t ctrl,
  input  wire rmf_pkg::age_t       idx,
  input  wire rmf_pkg::sample_t    prev_value,
  input  wire rmf_pkg::age_t       prev_age,
  input  wire logic                prev_le,
  input  wire rmf_pkg::sample_t    next_value,
  input  wire rmf_pkg::age_t       next_age,
  input  wire logic                next_le,
  input  wire logic                below_del,
  output rmf_pkg::sample_t         value,
  output rmf_pkg::age_t            age,
  output logic                     le,
  output logic                     del,
  output logic                     upto_del
);

  logic             active;
  rmf_pkg::sample_t value_next;
  rmf_pkg::age_t    age_next;

  assign active   = (idx <= ctrl.last);
  assign le       = active && (value <= ctrl.x);
  assign del      = active && (age == ctrl.last);
  assign upto_del = below_del | del;

  always_comb begin
    value_next = value;
    age_next   = age;
    if (ctrl.step && active) begin
      age_next = rmf_pkg::age_t'(age + 1'b1);
      if (ctrl.up_mode) begin
        // hole moves up: slots from the oldest one up to the insert point
        if (upto_del) begin
          if (next_le) begin
            value_next = next_value;
            age_next   = rmf_pkg::age_t'(next_age + 1'b1);
          end else if (le) begin
            value_next = ctrl.x;
            age_next   = '0;
          end
        end
      end else begin
        // hole moves down
        if (!below_del && !le) begin
          if (prev_le) begin
            value_next = ctrl.x;
            age_next   = '0;
          end else begin
            value_next = prev_value;
            age_next   = rmf_pkg::age_t'(prev_age + 1'b1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
      age   <= idx;
    end else if (ctrl.reinit) begin
      value <= ctrl.init;
      age   <= idx;
    end else begin
      value <= value_next;
      age   <= age_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rmf_out.sv
// Output stage: picks the median slot once the window has taken a sample and the output is free.
// Depends on rmf_pkg.
`default_nettype none

module rmf_out (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire rmf_pkg::sample_t values [rmf_pkg::MAX_WINDOW],
  input  wire rmf_pkg::age_t    mid,
  input  wire logic             m_ready,
  output logic                  m_valid,
  output rmf_pkg::sample_t      median,
  output logic                  s_ready,
  output logic                  pending
);

  logic can_load;

  assign can_load = !m_valid || m_ready;
  assign s_ready  = !pending || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      pending <= accept | (pending & !can_load);
      if (pending && can_load) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pending && can_load) begin
      median <= values[mid];
    end
  end

endmodule

`default_nettype wire
